// ===== rtl/core/tksq_pkg.sv =====
// ----------------------------------------------------------------------------
// tksq_pkg: two-key sorted priority queue shared types
// entry layout, request and status codes, cell control bundle
// ----------------------------------------------------------------------------
package tksq_pkg;

    localparam int DEFAULT_DEPTH = 8;
    localparam int TAG_W         = 16;
    localparam int SCORE_W       = 7;
    localparam int FILL_W        = 4;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [SCORE_W-1:0] second;
        logic [SCORE_W-1:0] first;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/tksq_cell.sv =====
// ----------------------------------------------------------------------------
// tksq_cell: one slot of the sorted queue
// compares the incoming entry with its own and shifts toward or away from head
// ----------------------------------------------------------------------------
module tksq_cell (
    input  logic                aclk,
    input  tksq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                prev_before,
    input  tksq_pkg::entry_t    prev_entry,
    input  tksq_pkg::entry_t    next_entry,
    output logic                ahead,
    output tksq_pkg::entry_t    entry
);

    tksq_pkg::entry_t entry_reg;
    tksq_pkg::entry_t entry_next;

    // new entry goes ahead of this slot
    always_comb begin
        ahead = !occupied
             || (entry_reg.first < ctrl.new_entry.first)
             || ((entry_reg.first == ctrl.new_entry.first)
                 && (entry_reg.second < ctrl.new_entry.second));
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (prev_before) begin
                entry_next = prev_entry;
            end else if (ahead) begin
                entry_next = ctrl.new_entry;
            end
        end else if (ctrl.rem) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/two_key_sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// two_key_sorted_priority_queue_unit: bounded two-key sorted priority queue
// output: result registered in the output register when the request is accepted
// throughput: one request per cycle while m_tready allows it, set by a single
//   compare-and-shift pass through the row of slot cells
// reset: aresetn synchronous active low, clears count and output valid
// ----------------------------------------------------------------------------
module two_key_sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = tksq_pkg::DEFAULT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_tag[15:0], in_first_score[22:16],
                                   // in_second_score[29:23], zero[31:30]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_tag[15:0], out_first_score[22:16],
                                   // out_second_score[29:23], fill_count[33:30],
                                   // zero[39:34]
    output logic [2:0]  m_tuser    // status[1:0], out_valid[2]
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    tksq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic                 cell_before [QUEUE_DEPTH];
    tksq_pkg::cell_ctrl_t ctrl;
    tksq_pkg::req_t       req;
    tksq_pkg::entry_t     zero_entry;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          accept;
    logic          full;
    logic          empty;

    logic          m_tvalid_reg;
    logic [39:0]   m_tdata_reg;
    logic [39:0]   m_tdata_next;
    logic [2:0]    m_tuser_reg;
    logic [2:0]    m_tuser_next;
    logic [CW+3:0] count_ext;

    assign req        = tksq_pkg::req_t'(s_tuser[0]);
    assign zero_entry = '0;
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign full       = (count_reg >= CW'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);

    always_comb begin
        ctrl.new_entry.tag    = s_tdata[15:0];
        ctrl.new_entry.first  = s_tdata[22:16];
        ctrl.new_entry.second = s_tdata[29:23];
        ctrl.ins = accept && (req == tksq_pkg::REQ_INSERT) && !full;
        ctrl.rem = accept && (req == tksq_pkg::REQ_REMOVE) && !empty;
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic             occ;
            logic             p_before;
            tksq_pkg::entry_t p_entry;
            tksq_pkg::entry_t n_entry;

            assign occ = (CW'(gi) < count_reg);

            if (gi == 0) begin : g_head
                assign p_before = 1'b0;
                assign p_entry  = ctrl.new_entry;
            end else begin : g_body
                assign p_before = cell_before[gi-1];
                assign p_entry  = cell_entry[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign n_entry = cell_entry[gi];
            end else begin : g_mid
                assign n_entry = cell_entry[gi+1];
            end

            tksq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (occ),
                .prev_before (p_before),
                .prev_entry  (p_entry),
                .next_entry  (n_entry),
                .ahead       (cell_before[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_ext = {4'b0, count_next};

    always_comb begin
        tksq_pkg::entry_t got;
        tksq_pkg::status_t st;
        got = zero_entry;
        st  = tksq_pkg::ST_DONE;
        if (req == tksq_pkg::REQ_INSERT) begin
            if (full) begin
                st = tksq_pkg::ST_FULL;
            end
        end else begin
            if (empty) begin
                st = tksq_pkg::ST_EMPTY;
            end else begin
                got = cell_entry[0];
            end
        end
        m_tdata_next = {6'b0, count_ext[3:0], got.second, got.first, got.tag};
        m_tuser_next = {ctrl.rem, st};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
